FILE: hdl/lms_pkg.sv
package lms_pkg;

	// Panel geometry
	localparam int COLUMNS   = 96;
	localparam int LINES     = 64;
	localparam int SCAN_ROWS = 16;  // must not exceed LINES

	localparam int BPL       = COLUMNS / 8;      // bytes per line
	localparam int PLANE     = LINES * BPL;      // bytes per color plane
	localparam int FRAME     = 2 * PLANE;        // red plane, then green plane
	localparam int BUFFERS   = 3;
	localparam int MEM_DEPTH = BUFFERS * PLANE;  // entries per color memory

	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int FILL_W = $clog2(FRAME);
	localparam int OFF_W  = $clog2(PLANE);
	localparam int LINE_W = $clog2(LINES);
	localparam int SROW_W = $clog2(SCAN_ROWS);
	localparam int BPL_W  = $clog2(BPL);
	localparam int SEL_W  = 2;

	// Operation codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Reset values
	localparam logic [7:0]       LIMIT_RST   = 8'd60;
	localparam logic [7:0]       BLANK_BYTE  = 8'hFF;
	localparam logic [SEL_W-1:0] USER_RST    = 2'd0;
	localparam logic [SEL_W-1:0] WAIT_RST    = 2'd1;
	localparam logic [SEL_W-1:0] DISPLAY_RST = 2'd2;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [7:0] red_bits;
		logic [7:0] green_bits;
		logic [3:0] row_select;
		logic       last;
	} res_t;

	// Write port of the frame store
	typedef struct packed {
		logic              en_red;
		logic              en_green;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

endpackage

FILE: hdl/lms_frame_store.sv
module lms_frame_store
	import lms_pkg::*;
(
	input  logic              clk,
	input  wr_t               wr,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_red,
	output logic [7:0]        rd_green
);

	// One memory per color plane, same address for a pixel in both
	logic [7:0] red_mem   [MEM_DEPTH];
	logic [7:0] green_mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en_red) begin
			red_mem[wr.addr] <= wr.data;
		end
		if (wr.en_green) begin
			green_mem[wr.addr] <= wr.data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_red   <= red_mem[rd_addr];
		rd_green <= green_mem[rd_addr];
	end

endmodule

FILE: hdl/led_matrix_scan_triple_buffer.sv
// Triple-buffered 1/16 scan controller for a red/green LED matrix. A data
// byte (operation 0) is written to the frame store as it is taken, and busy
// stays low. A refresh tick (operation 1) holds busy high while the address
// sequencer reads the 48 byte pairs of one scan row from the frame store,
// one pair per cycle; each pair appears on result for exactly one cycle with
// result_strobe, once the registered read has returned it, and the receiver
// cannot stall it. After reset the frame store is filled with 0xFF by a
// clearing pass (one entry of each plane per cycle) during which busy is
// high; cfg_wen is honored at any time.
module led_matrix_scan_triple_buffer
	import lms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       command,
	output logic       result_strobe,
	output res_t       result,
	input  logic       cfg_wen,
	input  logic [7:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CLEAR = 3'b010,
		S_SCAN  = 3'b100
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  clr_cnt_q;
	logic [7:0]         limit_q;
	logic [SEL_W-1:0]   user_sel_q, wait_sel_q, disp_sel_q;
	logic               pending_q;
	logic [FILL_W-1:0]  fill_q;
	logic [7:0]         idle_q;
	logic [SROW_W-1:0]  scan_row_q;

	// scan sequencer registers
	logic [ADDR_W-1:0]  base_q;
	logic [OFF_W-1:0]   line_off_q;
	logic [LINE_W-1:0]  line_q;
	logic [BPL_W-1:0]   top_q;
	logic [BPL_W-1:0]   j_q;

	logic               valid_s1;
	logic [3:0]         row_s1;
	logic               last_s1;

	wr_t                wr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [7:0]         rd_red, rd_green;

	logic               take;
	logic               take_data, take_tick;
	logic               group_end, last_group, last_line, row_end;
	logic               fill_green;
	logic [FILL_W-1:0]  fill_off;
	logic [7:0]         idle_inc;

	assign busy      = (state_q != S_IDLE);
	assign take      = start && !busy;
	assign take_data = take && (command.operation == OP_DATA);
	assign take_tick = take && (command.operation == OP_TICK);

	assign group_end  = (j_q == top_q);
	assign last_group = (top_q < 4);
	assign last_line  = (line_q < SCAN_ROWS);
	assign row_end    = (state_q == S_SCAN) && group_end && last_group && last_line;
	assign idle_inc   = idle_q + 8'd1;

	// Byte address within the user buffer
	assign fill_green = (fill_q >= PLANE);
	assign fill_off   = fill_green ? (fill_q - FILL_W'(PLANE)) : fill_q;

	// Write port: clearing pass or data byte
	always_comb begin
		wr = '0;
		if (state_q == S_CLEAR) begin
			wr.en_red   = 1'b1;
			wr.en_green = 1'b1;
			wr.addr     = clr_cnt_q;
			wr.data     = BLANK_BYTE;
		end else begin
			wr.en_red   = take_data && !fill_green;
			wr.en_green = take_data && fill_green;
			wr.addr     = ADDR_W'(int'(user_sel_q) * PLANE) + ADDR_W'(fill_off);
			wr.data     = command.data_byte;
		end
	end

	// Shared address adder for the scan
	assign rd_addr = base_q + ADDR_W'(line_off_q) + ADDR_W'(j_q);

	lms_frame_store u_store (
		.clk      (clk),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.rd_red   (rd_red),
		.rd_green (rd_green)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == ADDR_W'(MEM_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take_tick) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (row_end) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Line, group and byte walk; no reset needed, loaded on each tick
	always_ff @(posedge clk) begin
		if (take_tick) begin
			base_q     <= ADDR_W'(int'(disp_sel_q) * PLANE);
			line_q     <= LINE_W'(LINES - SCAN_ROWS + int'(scan_row_q));
			line_off_q <= OFF_W'((LINES - SCAN_ROWS + int'(scan_row_q)) * BPL);
			top_q      <= BPL_W'(BPL - 1);
			j_q        <= BPL_W'(BPL - 4);
		end else if (state_q == S_SCAN) begin
			if (!group_end) begin
				j_q <= j_q + BPL_W'(1);
			end else if (!last_group) begin
				top_q <= top_q - BPL_W'(4);
				j_q   <= (top_q >= 7) ? (top_q - BPL_W'(7)) : '0;
			end else if (!last_line) begin
				line_q     <= line_q - LINE_W'(SCAN_ROWS);
				line_off_q <= line_off_q - OFF_W'(SCAN_ROWS * BPL);
				top_q      <= BPL_W'(BPL - 1);
				j_q        <= BPL_W'(BPL - 4);
			end
		end
	end

	// Buffer rotation, fill index, idle frames, scan row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_sel_q <= USER_RST;
			wait_sel_q <= WAIT_RST;
			disp_sel_q <= DISPLAY_RST;
			pending_q  <= 1'b0;
			fill_q     <= '0;
			idle_q     <= '0;
			scan_row_q <= '0;
		end else if (take_data) begin
			idle_q <= '0;
			if (fill_q == FILL_W'(FRAME - 1)) begin
				fill_q     <= '0;
				user_sel_q <= wait_sel_q;
				wait_sel_q <= user_sel_q;
				pending_q  <= 1'b1;
			end else begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end else if (row_end) begin
			if (scan_row_q == SROW_W'(SCAN_ROWS - 1)) begin
				scan_row_q <= '0;
				if (pending_q) begin
					disp_sel_q <= wait_sel_q;
					wait_sel_q <= disp_sel_q;
					pending_q  <= 1'b0;
				end
				if (idle_inc == limit_q) begin
					fill_q <= '0;
					idle_q <= '0;
				end else begin
					idle_q <= idle_inc;
				end
			end else begin
				scan_row_q <= scan_row_q + SROW_W'(1);
			end
		end
	end

	// Read data lands in the cycle after the address; carry row and last with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		row_s1  <= 4'(scan_row_q);
		last_s1 <= row_end;
	end

	assign result_strobe     = valid_s1;
	assign result.red_bits   = rd_red;
	assign result.green_bits = rd_green;
	assign result.row_select = row_s1;
	assign result.last       = last_s1;

	// Checks
	a_strobe_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(state_q == S_SCAN))
		else $error("result transfer without a scan cycle");

	a_tick_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		take_tick |=> (state_q == S_SCAN))
		else $error("tick did not start a scan");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |=> !result_strobe)
		else $error("transfer directly after last pair");

	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FRAME)
		else $error("fill index out of range");

	a_row_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !result.last) |=> (result_strobe && $stable(result.row_select)))
		else $error("row pairs not contiguous");

endmodule
